// ===== rtl/core/gyro_heading_integrator_unit_defines.svh =====
`ifndef GYRO_HEADING_INTEGRATOR_UNIT_DEFINES_SVH
`define GYRO_HEADING_INTEGRATOR_UNIT_DEFINES_SVH

// clocked check, held off while in reset
`define GHI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define GHI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GHI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ghi_pkg.sv =====
`timescale 1ns / 1ps

package ghi_pkg;

  typedef enum logic [1:0] {
    OP_CAL = 2'd0,
    OP_RST = 2'd1,
    OP_UPD = 2'd2
  } op_e;

  // calibration run length, a power of two
  localparam int unsigned CAL_SHIFT   = 10;
  localparam int unsigned CAL_SAMPLES = 1 << CAL_SHIFT;
  localparam int unsigned CAL_CNT_W   = 13;

  // heading increment = rate * dt * MUL_GAIN / DIV_DEN, by reciprocal
  // multiplication: |rate * dt| < 2^31 and the rounding error of the
  // reciprocal is below DIV_DEN, so a 2^56 scale gives the exact quotient
  localparam int unsigned MAG_W  = 31;
  localparam int unsigned QUOT_W = 32;
  localparam int unsigned RCP_W  = 56;
  localparam int unsigned RCP_H  = 28;
  localparam int unsigned MPY_W  = MAG_W + RCP_H;
  localparam int unsigned ACC_W  = MPY_W + 1;

  localparam logic [79:0] MUL_GAIN = 80'd14680064;
  localparam logic [79:0] DIV_DEN  = 80'd17578125;
  localparam logic [79:0] RCP_FULL = ((MUL_GAIN << RCP_W) + DIV_DEN - 80'd1) / DIV_DEN;
  localparam logic [RCP_H-1:0] RCP_LO = RCP_FULL[RCP_H-1:0];
  localparam logic [RCP_H-1:0] RCP_HI = RCP_FULL[RCP_W-1:RCP_H];

  localparam logic [25:0] DEG_SCALE = 26'd360;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/ghi_div.sv =====
`timescale 1ns / 1ps

module ghi_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ghi_pkg::MAG_W-1:0]   num_i,
  output logic [ghi_pkg::QUOT_W-1:0]  quot_o,
  output ghi_pkg::div_stat_t          stat_o
);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [ghi_pkg::MAG_W-1:0]  x_q;
  logic [ghi_pkg::MPY_W-1:0]  lo_q;
  logic [ghi_pkg::QUOT_W-1:0] quot_q;
  logic [ghi_pkg::MAG_W-1:0]  mul_a;
  logic [ghi_pkg::RCP_H-1:0]  mul_b;
  logic [ghi_pkg::MPY_W-1:0]  mul_p;
  logic [ghi_pkg::ACC_W-1:0]  acc;

  // one shared multiplier: low reciprocal half at start, high half next cycle
  assign mul_a = busy_q ? x_q : num_i;
  assign mul_b = busy_q ? ghi_pkg::RCP_HI : ghi_pkg::RCP_LO;
  assign mul_p = ghi_pkg::MPY_W'(mul_a) * ghi_pkg::MPY_W'(mul_b);
  assign acc   = {1'b0, mul_p} + ghi_pkg::ACC_W'(lo_q[ghi_pkg::MPY_W-1:ghi_pkg::RCP_H]);

  always_comb begin
    busy_d = 1'b0;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
    end else if (busy_q) begin
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q  <= num_i;
      lo_q <= mul_p;
    end
    if (busy_q) begin
      quot_q <= acc[ghi_pkg::ACC_W-1:ghi_pkg::RCP_H];
    end
  end

  assign quot_o      = quot_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== rtl/core/gyro_heading_integrator_unit.sv =====
`timescale 1ns / 1ps
// Gyro yaw-rate integrator with bias calibration.
// Input stream: one request per gyro sample; tuser selects calibrate sample,
// heading reset or integrate update, tdata carries the raw rate and the
// 16-bit microsecond timestamp. Output stream: one result per request with
// heading (2^32 = full turn), whole degrees, corrected rate, bias and the
// calibrated flag.
// Sequence: calibrate, reset and unused selector pass from acceptance
// through the execute and finish states to tvalid. An update runs through
// rate times interval, two passes through the shared multiplier for the
// reciprocal of the scale divisor, a wait to see the unit done, the heading
// add and the output load. One request at a time: s_axis_tready is high
// only while the sequencer is idle, so no request is taken mid-sequence.
// The next request may be accepted while a result still waits in the
// output register.
// Reset clears heading, timestamp, bias and calibration progress to zero.
// If the receiver stalls, the result holds in the output register and the
// sequencer waits before publishing the next one.
`include "gyro_heading_integrator_unit_defines.svh"

module gyro_heading_integrator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // raw_rate[15:0], time_us[31:16]
  input  logic [1:0]  s_axis_tuser_i,   // operation[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // heading_angle[31:0], heading_degrees[40:32], corrected_rate[56:41],
  // bias_offset[72:57], calibrated[73], zero pad[79:74]
  output logic [79:0] m_axis_tdata_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_MULK = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]                     state_q, state_d;
  logic [31:0]                    heading_q, heading_d;
  logic [15:0]                    last_time_q, last_time_d;
  logic [15:0]                    bias_q, bias_d;
  logic [31:0]                    cal_sum_q, cal_sum_d;
  logic [ghi_pkg::CAL_CNT_W-1:0]  cal_count_q, cal_count_d;
  logic                           cal_done_q, cal_done_d;
  logic [15:0]                    last_rate_q, last_rate_d;
  logic                           out_valid_q, out_valid_d;

  logic [1:0]                     op_q;
  logic [15:0]                    raw_q;
  logic [15:0]                    t_q;
  logic [ghi_pkg::MAG_W-1:0]      prod_q, prod_d;
  logic [15:0]                    rate_q, rate_d;
  logic [79:0]                    out_data_q, out_data_d;

  logic                           in_req;
  logic                           out_load;
  logic [15:0]                    rate_w;
  logic [16:0]                    rate_sx;
  logic [16:0]                    mag;
  logic [15:0]                    dt;
  logic [32:0]                    prod_w;
  logic [31:0]                    sum_new;
  logic [ghi_pkg::CAL_CNT_W-1:0]  cnt_new;
  logic [31:0]                    sum_bias;
  logic [31:0]                    inc;
  logic [25:0]                    deg_prod;
  logic                           div_start;
  logic [ghi_pkg::QUOT_W-1:0]     quot;
  ghi_pkg::div_stat_t             div_stat;

  assign in_req          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign div_start       = (state_q == ST_MULK);
  assign out_load        = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready_i);

  // update datapath
  assign rate_w  = raw_q - bias_q;
  assign rate_sx = {rate_w[15], rate_w};
  assign mag     = rate_w[15] ? (~rate_sx + 17'd1) : rate_sx;
  assign dt      = t_q - last_time_q;
  assign prod_w  = 33'(mag) * 33'(dt);
  assign inc     = rate_q[15] ? (32'd0 - quot) : quot;

  // calibration datapath, average truncated toward zero
  assign sum_new  = cal_sum_q + {{16{raw_q[15]}}, raw_q};
  assign cnt_new  = cal_count_q + 1'b1;
  assign sum_bias = sum_new + (sum_new[31] ? 32'(ghi_pkg::CAL_SAMPLES - 1) : 32'd0);

  // floor((signed heading[31:16] * 360) / 2^16)
  assign deg_prod = {{10{heading_q[31]}}, heading_q[31:16]} * ghi_pkg::DEG_SCALE;

  ghi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .quot_o  (quot),
    .stat_o  (div_stat)
  );

  always_comb begin
    state_d     = state_q;
    heading_d   = heading_q;
    last_time_d = last_time_q;
    bias_d      = bias_q;
    cal_sum_d   = cal_sum_q;
    cal_count_d = cal_count_q;
    cal_done_d  = cal_done_q;
    last_rate_d = last_rate_q;
    out_valid_d = out_valid_q;
    prod_d      = prod_q;
    rate_d      = rate_q;
    out_data_d  = out_data_q;

    if (m_axis_tvalid_o && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_req) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_FIN;
        case (ghi_pkg::op_e'(op_q))
          ghi_pkg::OP_CAL: begin
            cal_sum_d   = sum_new;
            cal_count_d = cnt_new;
            if (cnt_new >= ghi_pkg::CAL_CNT_W'(ghi_pkg::CAL_SAMPLES)) begin
              bias_d      = sum_bias[ghi_pkg::CAL_SHIFT+15:ghi_pkg::CAL_SHIFT];
              cal_done_d  = 1'b1;
              cal_sum_d   = '0;
              cal_count_d = '0;
            end
          end
          ghi_pkg::OP_RST: begin
            heading_d   = '0;
            last_time_d = t_q;
          end
          ghi_pkg::OP_UPD: begin
            prod_d  = prod_w[ghi_pkg::MAG_W-1:0];
            rate_d  = rate_w;
            state_d = ST_MULK;
          end
          default: begin
            state_d = ST_FIN;
          end
        endcase
      end
      ST_MULK: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_stat.done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        heading_d   = heading_q + inc;
        last_time_d = t_q;
        last_rate_d = rate_q;
        state_d     = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_data_d  = {6'd0, cal_done_q, bias_q, last_rate_q, deg_prod[24:16], heading_q};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      heading_q   <= '0;
      last_time_q <= '0;
      bias_q      <= '0;
      cal_sum_q   <= '0;
      cal_count_q <= '0;
      cal_done_q  <= 1'b0;
      last_rate_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      heading_q   <= heading_d;
      last_time_q <= last_time_d;
      bias_q      <= bias_d;
      cal_sum_q   <= cal_sum_d;
      cal_count_q <= cal_count_d;
      cal_done_q  <= cal_done_d;
      last_rate_q <= last_rate_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req) begin
      op_q  <= s_axis_tuser_i;
      raw_q <= s_axis_tdata_i[15:0];
      t_q   <= s_axis_tdata_i[31:16];
    end
    prod_q     <= prod_d;
    rate_q     <= rate_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `GHI_ASSERT_IMP(a_ready_div_idle, s_axis_tready_o, !div_stat.busy && !div_stat.done, "divider active while idle")
  `GHI_ASSERT_IMP(a_done_in_wait, div_stat.done, state_q == ST_WAIT, "divider result outside wait state")
  `GHI_ASSERT_NXT(a_start_busy, div_start, div_stat.busy, "divider did not start")
  `GHI_ASSERT(a_cal_count_range, cal_count_q < ghi_pkg::CAL_CNT_W'(ghi_pkg::CAL_SAMPLES), "calibration count overrun")

endmodule
